FILE: sv/assert_macros.svh
// Assertion helper macros used by the record queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define LPP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define LPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lpp_pkg.sv
// ----------------------------------------------------------------------------
// Lidar point packet parser package
// Shared constants, result codes and the queue record type.
// ----------------------------------------------------------------------------
package lpp_pkg;

  localparam int GroupsPerPacket = 8;
  localparam int PointsPerGroup  = 16;
  localparam int PacketBytes     = 1024;

  localparam int GroupBytes  = 4 + 4 * PointsPerGroup;
  localparam int RegionBytes = GroupBytes * GroupsPerPacket;
  localparam int PosW        = 12;
  localparam int OffW        = $clog2(GroupBytes + 1);
  localparam logic [PosW-1:0] PosMax      = 12'hFFF;
  localparam logic [10:0]     CountMax    = 11'h7FF;
  localparam logic [PosW-1:0] RegionEnd   = PosW'(RegionBytes);
  localparam logic [PosW-1:0] TrailBase   = PosW'(PacketBytes - 8);
  localparam logic [PosW-1:0] PktLen      = PosW'(PacketBytes);
  localparam logic [OffW-1:0] GroupBytesC = OffW'(GroupBytes);

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_HDR   = 2'd2,
    KIND_SHORT = 2'd3
  } kind_t;

  // Record passed from the front to the back stage.
  typedef struct packed {
    logic        is_close;
    kind_t       kind;
    logic [15:0] angle;
    logic [15:0] distance;
    logic [7:0]  intensity;
    logic [1:0]  flags;
    logic        sync;
    logic        inval;
    logic        fmt;
    logic        full_len;
    logic        long_len;
    logic [31:0] stamp_hi;
    logic [31:0] stamp_lo;
    logic [7:0]  idx_byte;
    logic [10:0] count;
  } rec_t;

endpackage

FILE: sv/lidar_point_packet_parser_unit.sv
// ----------------------------------------------------------------------------
// Lidar point packet parser
// Parses packet bytes into point results and one closing result per packet.
// ----------------------------------------------------------------------------
// Takes one byte per cycle with no gaps needed while in_stall is low: the front
// end decodes each byte into its record register, and a two-entry queue
// decouples it from a three-stage back end whose two registered multiplies form
// the timestamp; a result passes the queue, stages 1 and 2 and the output
// register. A downstream stall fills the back end and queue before the input is stalled.
module lidar_point_packet_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_packet,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_angle_hundredths,
  output logic [15:0] out_distance,
  output logic [7:0]  out_intensity,
  output logic [1:0]  out_flag_bits,
  output logic        out_sync_mark,
  output logic        out_invalid_mark,
  output logic [63:0] out_time_stamp,
  output logic [7:0]  out_packet_index,
  output logic        out_packet_lost,
  output logic [10:0] out_point_count
);

  logic f_v, f_s, q_v, q_s;
  lpp_pkg::rec_t f_rec, q_rec;

  lpp_front u_front (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_data,
    .in_valid, .in_data_byte, .in_end_of_packet, .in_stall,
    .rec_valid(f_v), .rec(f_rec), .rec_stall(f_s)
  );

  lpp_queue u_queue (
    .clk, .rst_n, .wr_valid(f_v), .wr_rec(f_rec), .wr_stall(f_s),
    .rd_valid(q_v), .rd_rec(q_rec), .rd_stall(q_s)
  );

  lpp_back u_back (
    .clk, .rst_n, .rec_valid(q_v), .rec(q_rec), .rec_stall(q_s),
    .out_valid, .out_stall, .out_kind, .out_angle_hundredths, .out_distance,
    .out_intensity, .out_flag_bits, .out_sync_mark, .out_invalid_mark,
    .out_time_stamp, .out_packet_index, .out_packet_lost, .out_point_count
  );

endmodule

FILE: sv/lpp_front.sv
// ----------------------------------------------------------------------------
// Lidar parser front end
// Tracks the byte position, assembles fields and forms point and close records.
// ----------------------------------------------------------------------------
module lpp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_packet,
  output logic               in_stall,
  output logic               rec_valid,
  output lpp_pkg::rec_t      rec,
  input  logic               rec_stall
);

  localparam logic [0:0] RegHeader = 1'b0;

  logic [15:0] header_r;
  logic        fmt_r;
  logic [lpp_pkg::PosW-1:0] pos_r, pos_nxt;
  logic [lpp_pkg::OffW-1:0] off_r, off_nxt;
  logic [15:0] angle_r, angle_nxt, prev_r, prev_nxt;
  logic [15:0] fa_r, fa_nxt, si_r, si_nxt;
  logic [31:0] sa_r, sa_nxt, ts_r, ts_nxt;
  logic [7:0]  ib_r, ib_nxt;
  logic [10:0] cnt_r, cnt_nxt;
  logic [1:0]  sf_r, sf_nxt;
  logic        rv_r, rv_nxt;
  lpp_pkg::rec_t rec_r, rec_nxt;
  logic        acc;
  logic [15:0] asm16, new_ang;
  logic [1:0]  k;
  logic [lpp_pkg::PosW:0] len;
  logic        in_point;

  assign in_stall  = rv_r && rec_stall;
  assign acc       = in_valid && !in_stall;
  assign rec_valid = rv_r;
  assign rec       = rec_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= '0;
      fmt_r    <= 1'b1;
    end else if (cfg_wr_en) begin
      if (cfg_index == RegHeader) header_r <= cfg_data;
      else fmt_r <= cfg_data[0];
    end
  end

  // Per-byte decode.
  always_comb begin
    pos_nxt = pos_r; off_nxt = off_r; angle_nxt = angle_r; prev_nxt = prev_r;
    fa_nxt = fa_r; si_nxt = si_r; sa_nxt = sa_r; ts_nxt = ts_r; ib_nxt = ib_r;
    cnt_nxt = cnt_r; sf_nxt = sf_r; rv_nxt = rv_r && rec_stall; rec_nxt = rec_r;
    asm16 = {fa_r[7:0], in_data_byte};
    k = 2'(off_r - lpp_pkg::OffW'(4));
    new_ang = angle_r + {10'd0, si_r[13:8]};
    len = {1'b0, pos_r} + 1'b1;
    in_point = 1'b0;
    if (acc) begin
      // Trailer capture at fixed positions.
      if (pos_r >= lpp_pkg::TrailBase && pos_r < lpp_pkg::TrailBase + 4)
        sa_nxt = {sa_r[23:0], in_data_byte};
      else if (pos_r >= lpp_pkg::TrailBase + 4 && pos_r < lpp_pkg::TrailBase + 8)
        ts_nxt = {ts_r[23:0], in_data_byte};
      else if (pos_r == lpp_pkg::TrailBase + 8)
        ib_nxt = in_data_byte;
      // Group and point region.
      if (!in_end_of_packet && sf_r == 2'b00 && pos_r < lpp_pkg::RegionEnd) begin
        if (off_r == 0 || off_r == 2) fa_nxt = {8'd0, in_data_byte};
        else if (off_r == 1) begin
          fa_nxt = asm16;
          if (asm16 != header_r) sf_nxt[1] = 1'b1;
        end else if (off_r == 3) begin
          fa_nxt = asm16; angle_nxt = asm16;
        end else begin
          case (k)
            2'd0: si_nxt = {in_data_byte, 8'd0};
            2'd1: si_nxt = {si_r[15:8], in_data_byte};
            2'd2: fa_nxt = {8'd0, in_data_byte};
            default: begin
              fa_nxt = asm16;
              in_point = 1'b1;
            end
          endcase
        end
      end
      if (pos_r < lpp_pkg::RegionEnd)
        off_nxt = (off_r == lpp_pkg::GroupBytesC - 1'b1) ? '0 : off_r + 1'b1;
      if (pos_r < lpp_pkg::PosMax) pos_nxt = pos_r + 1'b1;
      if (in_point) begin
        angle_nxt = new_ang;
        prev_nxt  = new_ang;
        rec_nxt = '0;
        rec_nxt.kind      = lpp_pkg::KIND_POINT;
        rec_nxt.angle     = new_ang;
        rec_nxt.distance  = asm16;
        rec_nxt.intensity = si_r[7:0];
        rec_nxt.flags     = si_r[15:14];
        rec_nxt.sync      = ($signed({1'b0, prev_r}) - $signed({1'b0, new_ang})) > 17'sd100;
        rec_nxt.inval     = si_r == 16'd0 && (asm16 == 16'd0 || asm16 == 16'hFFFF);
        rv_nxt = 1'b1;
        if (cnt_r < lpp_pkg::CountMax) cnt_nxt = cnt_r + 1'b1;
        if (rec_nxt.inval) sf_nxt[0] = 1'b1;
      end
      // Packet close.
      if (in_end_of_packet) begin
        rec_nxt = '0;
        rec_nxt.is_close = 1'b1;
        rec_nxt.kind     = sf_r[1] ? lpp_pkg::KIND_HDR : lpp_pkg::KIND_DONE;
        rec_nxt.fmt      = fmt_r;
        rec_nxt.full_len = len >= lpp_pkg::PktLen;
        rec_nxt.long_len = len > lpp_pkg::PktLen;
        rec_nxt.stamp_hi = sa_nxt;
        rec_nxt.stamp_lo = ts_nxt;
        rec_nxt.idx_byte = ib_nxt;
        rec_nxt.count    = cnt_r;
        rv_nxt = 1'b1;
        pos_nxt = '0; off_nxt = '0; fa_nxt = '0; si_nxt = '0; sa_nxt = '0;
        ts_nxt = '0; ib_nxt = '0; cnt_nxt = '0; sf_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; off_r <= '0; angle_r <= '0; prev_r <= '0; fa_r <= '0;
      si_r <= '0; sa_r <= '0; ts_r <= '0; ib_r <= '0; cnt_r <= '0;
      sf_r <= '0; rv_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt; off_r <= off_nxt; angle_r <= angle_nxt; prev_r <= prev_nxt;
      fa_r <= fa_nxt; si_r <= si_nxt; sa_r <= sa_nxt; ts_r <= ts_nxt;
      ib_r <= ib_nxt; cnt_r <= cnt_nxt; sf_r <= sf_nxt; rv_r <= rv_nxt;
    end
    rec_r <= rec_nxt;
  end

endmodule

FILE: sv/lpp_queue.sv
// ----------------------------------------------------------------------------
// Lidar parser record queue
// Two-entry queue between the front and back stages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lpp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  input  lpp_pkg::rec_t wr_rec,
  output logic          wr_stall,
  output logic          rd_valid,
  output lpp_pkg::rec_t rd_rec,
  input  logic          rd_stall
);

  lpp_pkg::rec_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_stall = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_rec   = mem_r[rp_r];
  assign push = wr_valid && !wr_stall;
  assign pop  = rd_valid && !rd_stall;

  // Pointer and fill update.
  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= wr_rec;
  end

  `LPP_ASSERT_IMPL(a_fill_max, 1'b1, cnt_r <= 2'd2, "queue fill above two")
  `LPP_ASSERT_IMPL(a_ptr_fill, cnt_r == 2'd0 || cnt_r == 2'd2, wp_r == rp_r, "pointers disagree with fill")
  `LPP_ASSERT_NEXT(a_full_hold, wr_stall && rd_stall, $stable(cnt_r), "full queue changed without pop")

endmodule

FILE: sv/lpp_back.sv
// ----------------------------------------------------------------------------
// Lidar parser back end
// Builds the trailer fields and packet loss check, holds the output register.
// ----------------------------------------------------------------------------
module lpp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rec_valid,
  input  lpp_pkg::rec_t rec,
  output logic          rec_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    out_kind,
  output logic [15:0]   out_angle_hundredths,
  output logic [15:0]   out_distance,
  output logic [7:0]    out_intensity,
  output logic [1:0]    out_flag_bits,
  output logic          out_sync_mark,
  output logic          out_invalid_mark,
  output logic [63:0]   out_time_stamp,
  output logic [7:0]    out_packet_index,
  output logic          out_packet_lost,
  output logic [10:0]   out_point_count
);

  // Stage 1 registers: multiply seconds by 1000.
  logic        s1_v_r;
  lpp_pkg::rec_t s1_rec_r;
  logic [41:0] ms_r;
  // Stage 2: add ms then multiply by 1e6, split into a 32x20 low and an 11x20 high product.
  logic        s2_v_r;
  lpp_pkg::rec_t s2_rec_r;
  logic [51:0] p_lo_r, p_hi_r;
  logic [42:0] sum;
  // Output register.
  logic        ov_r;
  logic [1:0]  kind_r;
  logic [15:0] ang_r, dist_r;
  logic [7:0]  int_r, idx_r, pidx_r, pidx_nxt;
  logic [1:0]  flg_r;
  logic        syn_r, inv_r, lost_r;
  logic [63:0] ts_r;
  logic [10:0] cnt_r;
  logic        adv, s1_adv, s2_adv;
  logic [63:0] stamp;
  logic [7:0]  idx;
  logic [8:0]  dif;
  logic        lost;

  assign adv    = !(ov_r && out_stall);
  assign s2_adv = adv;
  assign s1_adv = !s2_v_r || s2_adv;
  assign rec_stall = s1_v_r && !s1_adv;

  assign sum = {1'b0, ms_r} + {11'd0, s1_rec_r.stamp_lo};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; ov_r <= 1'b0; pidx_r <= '0;
    end else begin
      if (!rec_stall) s1_v_r <= rec_valid;
      if (s1_adv) s2_v_r <= s1_v_r;
      if (adv) ov_r <= s2_v_r;
      pidx_r <= pidx_nxt;
    end
    if (!rec_stall && rec_valid) begin
      s1_rec_r <= rec;
      ms_r     <= {10'd0, rec.stamp_hi} * 42'd1000;
    end
    if (s1_adv && s1_v_r) begin
      s2_rec_r <= s1_rec_r;
      p_lo_r   <= {20'd0, sum[31:0]} * 52'd1000000;
      p_hi_r   <= {41'd0, sum[42:32]} * 52'd1000000;
    end
    if (adv && s2_v_r) begin
      kind_r <= (s2_rec_r.is_close && !s2_rec_r.full_len) ? lpp_pkg::KIND_SHORT
                                                          : s2_rec_r.kind;
      ang_r <= s2_rec_r.angle; dist_r <= s2_rec_r.distance;
      int_r <= s2_rec_r.intensity; flg_r <= s2_rec_r.flags; syn_r <= s2_rec_r.sync;
      inv_r <= s2_rec_r.inval; cnt_r <= s2_rec_r.count;
      ts_r <= stamp; idx_r <= idx; lost_r <= lost;
    end
  end

  // Trailer decode and loss check on close records.
  always_comb begin
    stamp = '0; idx = '0; pidx_nxt = pidx_r;
    if (s2_rec_r.fmt) begin
      stamp = {32'd0, s2_rec_r.stamp_hi};
      idx   = s2_rec_r.stamp_lo[31:24];
    end else if (s2_rec_r.long_len) begin
      stamp = {12'd0, p_lo_r} + {p_hi_r[31:0], 32'd0};
      idx   = {4'd0, s2_rec_r.idx_byte[3:0]};
    end
    dif  = {1'b0, idx} - {1'b0, pidx_r};
    lost = idx != 0 && pidx_r != 0 && dif != 9'd0 && dif != 9'd1 && dif != 9'h1FF;
    if (!s2_rec_r.is_close || !s2_rec_r.full_len) begin
      stamp = '0; idx = '0; lost = 1'b0;
    end
    if (adv && s2_v_r && s2_rec_r.is_close && s2_rec_r.full_len) pidx_nxt = idx;
  end

  assign out_valid = ov_r;
  assign out_kind = kind_r;
  assign out_angle_hundredths = ang_r;
  assign out_distance = dist_r;
  assign out_intensity = int_r;
  assign out_flag_bits = flg_r;
  assign out_sync_mark = syn_r;
  assign out_invalid_mark = inv_r;
  assign out_time_stamp = ts_r;
  assign out_packet_index = idx_r;
  assign out_packet_lost = lost_r;
  assign out_point_count = cnt_r;

endmodule
